// File: hdl/pcmsu_pkg.sv
// Package for the PCM byte stream sample unpacker: format codes, register
// indexes and the sample decode functions (mu-law, IEEE float to Q1.31).
// No dependencies.
package pcmsu_pkg;

    // Channel limit of one frame; the 4 bit channel index reaches 15
    localparam int MAX_CHANNELS = 16;

    // Sample format codes
    typedef enum logic [2:0] {
        FMT_MULAW8  = 3'd0,
        FMT_LIN8    = 3'd1,
        FMT_LIN16   = 3'd2,
        FMT_LIN24   = 3'd3,
        FMT_LIN32   = 3'd4,
        FMT_FLOAT32 = 3'd5,
        FMT_FLOAT64 = 3'd6
    } fmt_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] CFG_BIG_ENDIAN    = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [2:0] FORMAT_RESET        = FMT_LIN16;
    localparam logic [4:0] CHANNEL_COUNT_RESET = 5'd2;

    // Bytes per sample; zero for the unused format code
    function automatic logic [3:0] bytes_for_format(input logic [2:0] fmt);
        logic [3:0] n;
        case (fmt)
            FMT_MULAW8, FMT_LIN8:     n = 4'd1;
            FMT_LIN16:                n = 4'd2;
            FMT_LIN24:                n = 4'd3;
            FMT_LIN32, FMT_FLOAT32:   n = 4'd4;
            FMT_FLOAT64:              n = 4'd8;
            default:                  n = 4'd0;
        endcase
        return n;
    endfunction

    // G.711 mu-law code to 16 bit two's complement linear value
    function automatic logic [15:0] mulaw_decode(input logic [7:0] code);
        logic [7:0]  u;
        logic [2:0]  ex;
        logic [14:0] mag;
        u   = ~code;
        ex  = u[6:4];
        mag = ((15'({u[3:0], 3'b000}) + 15'h0084) << ex) - 15'h0084;
        return u[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    endfunction

    // IEEE float32 (low word) or float64 to Q1.31, truncate toward zero,
    // saturate at full scale, NaN gives zero
    function automatic logic [31:0] float_to_q31(input logic [63:0] g,
                                                 input logic        is_double);
        logic        sign;
        logic [10:0] e;
        logic [10:0] e_eff;
        logic [10:0] expmax;
        logic [10:0] bias;
        logic [51:0] frac;
        logic [52:0] m;
        logic [52:0] shifted;
        logic [11:0] sa;
        logic [31:0] mag;
        logic [31:0] res;
        if (is_double) begin
            sign   = g[63];
            e      = g[62:52];
            frac   = g[51:0];
            expmax = 11'h7FF;
            bias   = 11'd1023;
        end else begin
            sign   = g[31];
            e      = {3'b000, g[30:23]};
            frac   = {g[22:0], 29'd0};
            expmax = 11'h0FF;
            bias   = 11'd127;
        end
        // Mantissa aligned with its leading bit at bit 52 in both formats
        m       = {(e != 11'd0), frac};
        e_eff   = (e == 11'd0) ? 11'd1 : e;
        sa      = 12'd21 + {1'b0, bias} - {1'b0, e_eff};
        shifted = m >> sa[5:0];
        mag     = shifted[31:0];
        if (e == expmax) begin
            if (frac != 52'd0) begin
                res = 32'd0;
            end else begin
                res = sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end else if (e_eff >= bias) begin
            res = sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (sa > 12'd52) begin
            res = 32'd0;
        end else begin
            res = sign ? (32'd0 - mag) : mag;
        end
        return res;
    endfunction

endpackage

// File: hdl/pcm_byte_stream_sample_unpacker_top.sv
// Top level of the PCM byte stream sample unpacker: byte gather, sample
// decode register and result register. Depends on pcmsu_pkg.
//
// Usage:
//   The input channel (s_valid/s_ready/s_data_byte) takes one raw byte of an
//   interleaved audio stream per beat. Bytes are gathered into a sample in
//   the configured format and byte order; each completed sample leaves on
//   the result channel (m_valid/m_ready) as a Q1.31 value with its channel
//   index, frame index and an end-of-frame flag. Bytes that do not finish a
//   sample give no result; with the unused format code bytes are dropped.
//   Throughput: one byte per cycle, sustained, with the receiver ready.
//   After the beat of its last byte a result passes the decode register and
//   then the result register.
//   The decode register and the result register form a two deep pipeline,
//   so a new byte is taken while a result waits; when the receiver stalls
//   both fill and then s_ready drops until the result is taken.
//   Configuration (cfg_we/cfg_addr/cfg_wdata) is for the user to write only
//   while no sample is in flight; the block does not enforce this. Reset
//   (aresetn low, synchronous) restores 16 bit little endian stereo and
//   clears the gather, channel and frame positions.
module pcm_byte_stream_sample_unpacker_top
    import pcmsu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [4:0]         cfg_wdata,
    // byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    // sample output
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sample_value,
    output logic [3:0]         m_channel_number,
    output logic [31:0]        m_frame_number,
    output logic               m_frame_end
);

    // Configuration
    logic [2:0]  fmt_reg;
    logic        big_endian_reg;
    logic [4:0]  chan_count_reg;

    // Gather and position state
    logic [63:0] gather_reg;
    logic [63:0] gather_next;
    logic [2:0]  byte_pos_reg;
    logic [3:0]  chan_pos_reg;
    logic [31:0] frame_reg;

    // Decode register
    logic        a_valid_reg;
    logic [63:0] a_gather_reg;
    logic [2:0]  a_fmt_reg;
    logic [3:0]  a_chan_reg;
    logic [31:0] a_frame_reg;
    logic        a_last_reg;

    // Result register
    logic        m_valid_reg;
    logic [31:0] m_sample_reg;
    logic [3:0]  m_chan_reg;
    logic [31:0] m_frame_reg;
    logic        m_last_reg;

    logic [3:0]  need;
    logic        fmt_ok;
    logic        s_beat;
    logic        sample_done;
    logic        a_load;
    logic        a_advance;
    logic [4:0]  eff_count;
    logic        chan_last;
    logic [31:0] decoded;

    // Handshake
    assign a_advance = !m_valid_reg || m_ready;
    assign s_ready   = !a_valid_reg || a_advance;
    assign s_beat    = s_valid && s_ready;

    // Gather the new byte in the configured order
    assign need        = bytes_for_format(fmt_reg);
    assign fmt_ok      = (need != 4'd0);
    assign gather_next = big_endian_reg ? {gather_reg[55:0], s_data_byte}
                       : (gather_reg | (64'(s_data_byte) << {byte_pos_reg, 3'b000}));
    assign sample_done = (({1'b0, byte_pos_reg} + 4'd1) >= need);
    assign a_load      = s_beat && fmt_ok && sample_done;

    // Clamp the channel count to 1 .. MAX_CHANNELS
    always_comb begin
        if (chan_count_reg == 5'd0) begin
            eff_count = 5'd1;
        end else if (chan_count_reg > 5'(MAX_CHANNELS)) begin
            eff_count = 5'(MAX_CHANNELS);
        end else begin
            eff_count = chan_count_reg;
        end
    end
    assign chan_last = (({1'b0, chan_pos_reg} + 5'd1) >= eff_count);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg        <= FORMAT_RESET;
            big_endian_reg <= 1'b0;
            chan_count_reg <= CHANNEL_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SAMPLE_FORMAT: fmt_reg        <= cfg_wdata[2:0];
                CFG_BIG_ENDIAN:    big_endian_reg <= cfg_wdata[0];
                CFG_CHANNEL_COUNT: chan_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the gather, channel and frame positions on each byte beat of a used format
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gather_reg   <= 64'd0;
            byte_pos_reg <= 3'd0;
            chan_pos_reg <= 4'd0;
            frame_reg    <= 32'd0;
        end else if (s_beat && fmt_ok) begin
            if (sample_done) begin
                gather_reg   <= 64'd0;
                byte_pos_reg <= 3'd0;
                if (chan_last) begin
                    chan_pos_reg <= 4'd0;
                    frame_reg    <= frame_reg + 32'd1;
                end else begin
                    chan_pos_reg <= chan_pos_reg + 4'd1;
                end
            end else begin
                gather_reg   <= gather_next;
                byte_pos_reg <= byte_pos_reg + 3'd1;
            end
        end
    end

    // Decode register: hold a completed sample until the result stage frees
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_load) begin
            a_valid_reg <= 1'b1;
        end else if (a_advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_gather_reg <= gather_next;
            a_fmt_reg    <= fmt_reg;
            a_chan_reg   <= chan_pos_reg;
            a_frame_reg  <= frame_reg;
            a_last_reg   <= chan_last;
        end
    end

    // Decode the gathered bytes to Q1.31
    always_comb begin
        case (a_fmt_reg)
            FMT_MULAW8:  decoded = {mulaw_decode(a_gather_reg[7:0]), 16'd0};
            FMT_LIN8:    decoded = {a_gather_reg[7:0], 24'd0};
            FMT_LIN16:   decoded = {a_gather_reg[15:0], 16'd0};
            FMT_LIN24:   decoded = {a_gather_reg[23:0], 8'd0};
            FMT_LIN32:   decoded = a_gather_reg[31:0];
            FMT_FLOAT32: decoded = float_to_q31(a_gather_reg, 1'b0);
            FMT_FLOAT64: decoded = float_to_q31(a_gather_reg, 1'b1);
            default:     decoded = 32'd0;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_advance) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_advance && a_valid_reg) begin
            m_sample_reg <= decoded;
            m_chan_reg   <= a_chan_reg;
            m_frame_reg  <= a_frame_reg;
            m_last_reg   <= a_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sample_value   = $signed(m_sample_reg);
    assign m_channel_number = m_chan_reg;
    assign m_frame_number   = m_frame_reg;
    assign m_frame_end      = m_last_reg;

    // A completed sample leaves the gather empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_load |=> (gather_reg == 64'd0) && (byte_pos_reg == 3'd0))
        else $error("gather not cleared after completed sample");

    // A sample that is not the last of its frame lies below the channel count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_end) |-> (({1'b0, m_channel_number} + 5'd1) < eff_count))
        else $error("channel index beyond frame without frame end");

    // A decoded sample is held while the result stage is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !a_advance) |=> a_valid_reg && $stable(a_chan_reg)
                                        && $stable(a_frame_reg))
        else $error("decode register lost a stalled sample");

endmodule
